/* hdl/note_release_length_averager_top_defines.svh */
// Assertion macros used by the checker file.
`ifndef NOTE_RELEASE_LENGTH_AVERAGER_TOP_DEFINES_SVH
`define NOTE_RELEASE_LENGTH_AVERAGER_TOP_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define NRLA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define NRLA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* hdl/nrla_pkg.sv */
// ----------------------------------------------------------------------------
// nrla_pkg
// Shared constants and types of the note release length averager.
// ----------------------------------------------------------------------------
package nrla_pkg;
  localparam int MAX_FRAMES = 16;
  localparam int MAX_NOTES = 128;
  localparam int LEVEL_BITS = 7;
  localparam int SLOT_W = $clog2(MAX_FRAMES);
  localparam int POS_W = $clog2(MAX_NOTES);
  localparam int ADDR_W = SLOT_W + POS_W;
  localparam int DEPTH = MAX_FRAMES * MAX_NOTES;
  localparam int HELD_W = $clog2(MAX_FRAMES + 1);
  localparam int SUM_W = LEVEL_BITS + SLOT_W;
  localparam int FIU_W = 5;
  localparam int NIU_W = 8;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 8;
  localparam int RUN_W = 4;
  localparam int IDX_W = 7;
  localparam int SIL_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_FRAMES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NOTES = 1'd1;

  typedef struct packed {
    logic start;
    logic do_div;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic walk_done;
    logic div_done;
  } sts_t;
endpackage

/* hdl/nrla_if.sv */
// ----------------------------------------------------------------------------
// nrla_in_if / nrla_out_if / nrla_cfg_if
// Valid/ready channels of the note release length averager.
// ----------------------------------------------------------------------------
interface nrla_in_if;
  logic valid;
  logic ready;
  logic [nrla_pkg::LEVEL_BITS-1:0] level;
  logic last_in_frame;
  modport source (output valid, level, last_in_frame, input ready);
  modport sink (input valid, level, last_in_frame, output ready);
endinterface

interface nrla_out_if;
  logic valid;
  logic ready;
  logic [nrla_pkg::IDX_W-1:0] note_index;
  logic [nrla_pkg::RUN_W-1:0] run_length;
  logic [nrla_pkg::LEVEL_BITS-1:0] average_level;
  logic frame_end;
  logic [nrla_pkg::SIL_W-1:0] silent_frames;
  logic [nrla_pkg::SIL_W-1:0] previous_silent_frames;
  modport source (output valid, note_index, run_length, average_level, frame_end,
                  silent_frames, previous_silent_frames, input ready);
  modport sink (input valid, note_index, run_length, average_level, frame_end,
                silent_frames, previous_silent_frames, output ready);
endinterface

interface nrla_cfg_if;
  logic valid;
  logic ready;
  logic [nrla_pkg::CFG_IDX_W-1:0] index;
  logic [nrla_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hdl/nrla_ram.sv */
// ----------------------------------------------------------------------------
// nrla_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module nrla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

/* hdl/nrla_ctrl.sv */
// ----------------------------------------------------------------------------
// nrla_ctrl
// Sequencer: accept a word, walk the store, divide, present the result.
// ----------------------------------------------------------------------------
module nrla_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_fire,
  input  logic           out_fire,
  input  nrla_pkg::sts_t sts,
  output nrla_pkg::cmd_t cmd,
  output logic           in_ready,
  output logic           out_valid
);
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_WALK = 4'b0010,
    S_DIV  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.start = 1'b1;
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        cmd.step = 1'b1;
        if (sts.walk_done) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.do_div = 1'b1;
        if (sts.div_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule

/* hdl/nrla_dp.sv */
// ----------------------------------------------------------------------------
// nrla_dp
// Datapath: frame store, history walk, serial divider and frame counters.
// ----------------------------------------------------------------------------
module nrla_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  nrla_pkg::cmd_t                    cmd,
  output nrla_pkg::sts_t                    sts,
  input  logic [nrla_pkg::LEVEL_BITS-1:0]   level,
  input  logic                              last_in_frame,
  input  logic                              cfg_fire,
  input  logic [nrla_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [nrla_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic [nrla_pkg::IDX_W-1:0]        note_index,
  output logic [nrla_pkg::RUN_W-1:0]        run_length,
  output logic [nrla_pkg::LEVEL_BITS-1:0]   average_level,
  output logic                              frame_end,
  output logic [nrla_pkg::SIL_W-1:0]        silent_frames,
  output logic [nrla_pkg::SIL_W-1:0]        previous_silent_frames
);
  localparam int SW = nrla_pkg::SLOT_W;
  localparam int PW = nrla_pkg::POS_W;
  localparam int HW = nrla_pkg::HELD_W;
  localparam int LW = nrla_pkg::LEVEL_BITS;
  localparam int UW = nrla_pkg::SUM_W;
  localparam int FW = nrla_pkg::FIU_W;
  localparam int NW = nrla_pkg::NIU_W;
  localparam int XW = nrla_pkg::SIL_W;

  logic [FW-1:0] fiu_r;
  logic [NW-1:0] niu_r;
  logic [HW-1:0] held_r;
  logic [SW-1:0] slot_r;
  logic [PW-1:0] pos_r;
  logic silent_r;
  logic [XW-1:0] srun_r, prun_r;

  logic [HW-1:0] fu, win;
  logic [NW:0] nu;
  always_comb begin
    if (fiu_r == '0) fu = HW'(1);
    else if (32'(fiu_r) > nrla_pkg::MAX_FRAMES) fu = HW'(nrla_pkg::MAX_FRAMES);
    else fu = HW'(fiu_r);
    if (niu_r == '0) nu = (NW+1)'(1);
    else if (32'(niu_r) > nrla_pkg::MAX_NOTES) nu = (NW+1)'(nrla_pkg::MAX_NOTES);
    else nu = (NW+1)'(niu_r);
    win = (held_r + HW'(1) > fu) ? fu : held_r + HW'(1);
  end

  // Walk state.
  logic [SW-1:0] back_r;
  logic [HW-1:0] j_r, win_r;
  logic [UW-1:0] sum_r;
  logic [SW:0] run_r;
  logic end_r, rd_pend_r, walk_done_r, stop_r;

  logic ram_we;
  logic [nrla_pkg::ADDR_W-1:0] ram_addr;
  logic [LW-1:0] ram_rd;

  assign ram_we = cmd.start;
  assign ram_addr = cmd.start ? {slot_r, pos_r} : {slot_r - back_r, pos_r};

  nrla_ram #(.WIDTH(LW), .DEPTH(nrla_pkg::DEPTH)) u_store (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(level), .rdata(ram_rd)
  );

  // Divider state.
  logic [UW-1:0] rem_r, quo_r;
  logic [SW:0] dcnt_r;
  logic [UW:0] trial;
  assign trial = {rem_r, quo_r[UW-1]} - (UW+1)'(run_r);

  logic pos_end;
  assign pos_end = last_in_frame || ((NW+1)'(pos_r) + (NW+1)'(1) >= nu);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fiu_r <= FW'(16);
      niu_r <= NW'(88);
      held_r <= '0;
      slot_r <= '0;
      pos_r <= '0;
      silent_r <= 1'b1;
      srun_r <= '0;
      prun_r <= '0;
      walk_done_r <= 1'b0;
      rd_pend_r <= 1'b0;
      stop_r <= 1'b0;
    end else begin
      if (cfg_fire) begin
        unique case (cfg_index)
          nrla_pkg::REG_FRAMES: begin
            fiu_r <= cfg_data[FW-1:0];
            if (fiu_r != '0 || cfg_data[FW-1:0] != '0) begin
              if (cfg_data[FW-1:0] == '0) held_r <= (held_r > HW'(1)) ? HW'(1) : held_r;
              else if (32'(cfg_data[FW-1:0]) > nrla_pkg::MAX_FRAMES) begin
                held_r <= held_r;
              end else if (held_r > HW'(cfg_data[FW-1:0])) begin
                held_r <= HW'(cfg_data[FW-1:0]);
              end
            end else if (held_r > HW'(1)) begin
              held_r <= HW'(1);
            end
          end
          nrla_pkg::REG_NOTES: niu_r <= cfg_data;
          default: ;
        endcase
      end
      walk_done_r <= 1'b0;
      if (cmd.start) begin
        win_r <= win;
        end_r <= pos_end;
        note_index <= nrla_pkg::IDX_W'(pos_r);
        back_r <= SW'(1);
        j_r <= HW'(1);
        sum_r <= '0;
        run_r <= '0;
        rd_pend_r <= 1'b0;
        stop_r <= !(win >= HW'(2) && level == '0);
        if (level != '0) silent_r <= 1'b0;
      end else if (cmd.step) begin
        if (stop_r) begin
          walk_done_r <= 1'b1;
          if (walk_done_r) walk_done_r <= 1'b0;
        end else if (!rd_pend_r) begin
          rd_pend_r <= 1'b1;
        end else begin
          rd_pend_r <= 1'b0;
          if (ram_rd == '0) begin
            stop_r <= 1'b1;
          end else begin
            sum_r <= sum_r + UW'(ram_rd);
            run_r <= run_r + 1'b1;
            j_r <= j_r + HW'(1);
            back_r <= back_r + SW'(1);
            if (j_r + HW'(1) >= win_r) stop_r <= 1'b1;
          end
        end
      end
      if (cmd.step && sts.walk_done) begin
        rem_r <= '0;
        quo_r <= sum_r;
        dcnt_r <= '0;
      end
      if (cmd.do_div && !sts.div_done) begin
        if (run_r != '0 && !trial[UW]) begin
          rem_r <= trial[UW-1:0];
          quo_r <= {quo_r[UW-2:0], 1'b1};
        end else begin
          rem_r <= {rem_r[UW-2:0], quo_r[UW-1]};
          quo_r <= {quo_r[UW-2:0], 1'b0};
        end
        dcnt_r <= dcnt_r + 1'b1;
        if (32'(dcnt_r) == UW - 1) begin
          run_length <= nrla_pkg::RUN_W'(run_r);
          frame_end <= end_r;
          silent_frames <= '0;
          previous_silent_frames <= '0;
          if (end_r) begin
            silent_r <= 1'b1;
            pos_r <= '0;
            slot_r <= slot_r + SW'(1);
            if (held_r < fu) held_r <= held_r + HW'(1);
            silent_frames <= srun_r;
            previous_silent_frames <= prun_r;
            if (win_r >= HW'(2)) begin
              if (silent_r) begin
                if (srun_r != '1) begin
                  srun_r <= srun_r + XW'(1);
                  silent_frames <= srun_r + XW'(1);
                end
              end else begin
                prun_r <= srun_r;
                srun_r <= '0;
                silent_frames <= '0;
                previous_silent_frames <= srun_r;
              end
            end
          end else begin
            pos_r <= pos_r + PW'(1);
          end
        end
      end
      if (cmd.do_div && sts.div_done) begin
        average_level <= (run_r == '0) ? '0 : quo_r[LW-1:0];
      end
    end
  end

  assign sts.walk_done = walk_done_r;
  assign sts.div_done = (32'(dcnt_r) == UW);
endmodule

/* hdl/note_release_length_averager_top.sv */
// Per input word: the store is read back one frame per read (at most 15 reads),
// then the sum is divided by the run length with a restoring divide.
// One word at a time: a new word is accepted only after the result is taken.
// The store is a single-port RAM, read once per frame walked back.
// Reset (rst_n low, synchronous) sets 16 frames, 88 notes and clears frame counters.
// Frame store contents are not cleared by reset.
// ----------------------------------------------------------------------------
// note_release_length_averager_top
// Detects note releases and reports run length, mean level and silent frames.
// ----------------------------------------------------------------------------
module note_release_length_averager_top (
  input logic clk,
  input logic rst_n,
  nrla_in_if.sink in_ch,
  nrla_out_if.source out_ch,
  nrla_cfg_if.sink cfg_ch
);
  nrla_pkg::cmd_t cmd;
  nrla_pkg::sts_t sts;
  logic in_fire, out_fire;

  assign in_fire = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign cfg_ch.ready = 1'b1;

  nrla_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_fire(out_fire), .sts(sts),
    .cmd(cmd), .in_ready(in_ch.ready), .out_valid(out_ch.valid)
  );

  nrla_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .level(in_ch.level), .last_in_frame(in_ch.last_in_frame),
    .cfg_fire(cfg_ch.valid), .cfg_index(cfg_ch.index), .cfg_data(cfg_ch.data),
    .note_index(out_ch.note_index), .run_length(out_ch.run_length),
    .average_level(out_ch.average_level), .frame_end(out_ch.frame_end),
    .silent_frames(out_ch.silent_frames),
    .previous_silent_frames(out_ch.previous_silent_frames)
  );
endmodule

/* hdl/nrla_checker.sv */
// ----------------------------------------------------------------------------
// nrla_checker
// Port-level checks of the note release length averager.
// ----------------------------------------------------------------------------
`include "note_release_length_averager_top_defines.svh"
module nrla_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [nrla_pkg::RUN_W-1:0] run_length,
  input logic [nrla_pkg::LEVEL_BITS-1:0] average_level,
  input logic frame_end,
  input logic [nrla_pkg::SIL_W-1:0] silent_frames
);
  `NRLA_ASSERT_IMP(a_excl, clk, rst_n, out_valid, !in_ready)
  `NRLA_ASSERT_NEXT(a_busy, clk, rst_n, in_valid && in_ready, !in_ready)
  `NRLA_ASSERT_IMP(a_avg, clk, rst_n, out_valid && run_length == '0, average_level == '0)
  `NRLA_ASSERT_IMP(a_sil, clk, rst_n, out_valid && !frame_end, silent_frames == '0)
  `NRLA_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid)
endmodule

bind note_release_length_averager_top nrla_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .run_length(out_ch.run_length), .average_level(out_ch.average_level),
  .frame_end(out_ch.frame_end), .silent_frames(out_ch.silent_frames)
);
